// ===== src/apfc_pkg.sv =====
// apfc_pkg: shared widths, constants, register indexes and the command and
// status structs that pass between the controller and the datapath.
// No dependencies.
package apfc_pkg;

   // payload and register widths
   localparam int VM_W       = 16;
   localparam int CAP_W      = 16;
   localparam int RM_W       = 24;
   localparam int FRAC_W     = 9;
   localparam int LOG_W      = 8;
   localparam int SEEN_W     = 9;
   localparam int CYC_W      = 13;
   localparam int DRIVE_W    = 13;
   localparam int ERR_W      = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // shared divider sizing
   localparam int DIV_NUM_W = 42;
   localparam int DIV_DEN_W = 24;
   localparam int DIV_QUO_W = 16;
   localparam int DIV_CNT_W = 5;
   localparam int DIV_SH_W  = 6;

   // quotient bits each division needs
   localparam logic [DIV_CNT_W-1:0] QBITS_CYCLE = 5'd15;
   localparam logic [DIV_CNT_W-1:0] QBITS_TMPL  = 5'd16;
   localparam logic [DIV_CNT_W-1:0] QBITS_DRIVE = 5'd13;

   // limits
   localparam logic [DRIVE_W-1:0] DRIVE_MAX    = 13'd5120;
   localparam logic [CYC_W-1:0]   CYCLE_MAX    = 13'd8191;
   localparam logic [SEEN_W-1:0]  SEEN_MAX     = 9'd256;
   localparam logic [FRAC_W-1:0]  FRAC_MAX     = 9'd256;
   localparam logic [RM_W-1:0]    RM_MAX       = 24'hFFFFFF;
   // smallest rm that may halve: 0.02 megaohm
   localparam logic [RM_W-1:0]    RM_HALVE_MIN = 24'd6;

   // register defaults
   localparam logic [CAP_W-1:0]        CAP_RESET      = 16'd150;
   localparam logic [RM_W-1:0]         RM_RESET       = 24'd38400;
   localparam logic signed [VM_W-1:0]  V_CUTOFF_RESET = -16'sd10240;
   localparam logic [VM_W-1:0]         SLOPE_RESET    = 16'd1280;
   localparam logic [FRAC_W-1:0]       FRAC_RESET     = 9'd251;
   localparam logic [LOG_W-1:0]        LOG_RESET      = 8'd3;
   localparam logic [VM_W-1:0]         NOISE_RESET    = 16'd512;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAP_PF       = 3'd0,
      CSR_RM_START     = 3'd1,
      CSR_V_CUTOFF     = 3'd2,
      CSR_SLOPE_THRESH = 3'd3,
      CSR_CUT_FRAC     = 3'd4,
      CSR_LOG_COUNT    = 3'd5,
      CSR_NOISE_THRESH = 3'd6,
      CSR_ADAPT_ENABLE = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_CYCLE = 2'd0,
      DIV_TMPL  = 2'd1,
      DIV_DRIVE = 2'd2
   } div_op_type;

   typedef struct packed {
      logic       load_vm;
      logic       detect;
      logic       cyc_write;
      logic       tmpl_read;
      logic       tmpl_prep;
      logic       tmpl_write;
      logic       run_start;
      logic       run_read;
      logic       run_eval;
      logic       drive_check;
      logic       drive_write;
      logic       finish;
      logic       div_start;
      div_op_type div_op;
   } apfc_cmd_type;

   typedef struct packed {
      logic cyc_needed;
      logic avg_go;
      logic drive_div;
      logic drive_ovf;
      logic div_done;
   } apfc_stat_type;

endpackage

// ===== src/apfc_divider.sv =====
// apfc_divider: restoring divider, one quotient bit per cycle.
// The caller guarantees the quotient fits in qbits_i bits. Uses apfc_pkg.
module apfc_divider
   import apfc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start_i,
   input  logic [DIV_CNT_W-1:0] qbits_i,
   input  logic [DIV_NUM_W-1:0] numer_i,
   input  logic [DIV_DEN_W-1:0] denom_i,
   output logic                 done_o,
   output logic [DIV_QUO_W-1:0] quo_o
);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_QUO_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   trial_sub;
   logic                 fits;
   logic [DIV_SH_W-1:0]  align;

   // one trial subtraction per cycle
   always_comb begin
      trial     = {rem_ff, num_ff[DIV_NUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = trial >= {1'b0, den_ff};
      align     = DIV_SH_W'(DIV_NUM_W) - DIV_SH_W'(qbits_i);
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (start_i) begin
         cnt_in = qbits_i;
         num_in = numer_i << align;
         den_in = denom_i;
         rem_in = DIV_DEN_W'(numer_i >> qbits_i);
         quo_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
         num_in  = num_ff << 1;
         rem_in  = fits ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_in  = {quo_ff[DIV_QUO_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done_o = done_ff;
   assign quo_o  = quo_ff;

endmodule

// ===== src/apfc_datapath.sv =====
// apfc_datapath: lag ring, template memory, averaging and correction state,
// configuration registers and the shared divider. Uses apfc_pkg, apfc_divider.
module apfc_datapath
   import apfc_pkg::*;
#(
   parameter int LAG            = 10,
   parameter int TEMPLATE_DEPTH = 8192
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  apfc_cmd_type           cmd_i,
   output apfc_stat_type          stat_o,
   input  logic signed [VM_W-1:0] vm_i,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic [DRIVE_W-1:0]     drive_o,
   output logic                   correcting_o,
   output logic [SEEN_W-1:0]      aps_o,
   output logic [CYC_W-1:0]       cycle_o
);

   localparam int POS_W  = (LAG > 1) ? $clog2(LAG) : 1;
   localparam int WARM_W = $clog2(LAG + 1);
   localparam int ADDR_W = $clog2(TEMPLATE_DEPTH);
   localparam int IDX_W  = ADDR_W + 1;
   localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(LAG - 1);
   localparam logic [WARM_W-1:0] WARM_FULL = WARM_W'(LAG);
   localparam logic [IDX_W-1:0]  DEPTH_IDX = IDX_W'(TEMPLATE_DEPTH);
   localparam logic [ADDR_W-1:0] RUN_LAST  = ADDR_W'(TEMPLATE_DEPTH - 1);

   // configuration
   logic [CAP_W-1:0]        cap_ff, cap_in;
   logic signed [VM_W-1:0]  vcut_ff, vcut_in;
   logic [VM_W-1:0]         slope_ff, slope_in;
   logic [FRAC_W-1:0]       frac_ff, frac_in;
   logic [LOG_W-1:0]        log_ff, log_in;
   logic [VM_W-1:0]         noise_ff, noise_in;
   logic                    adapt_ff, adapt_in;

   // per-item and persistent state
   logic signed [VM_W-1:0]  vm_ff, vm_in;
   logic signed [VM_W-1:0]  ring_ff [LAG];
   logic signed [VM_W-1:0]  ring_in [LAG];
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [WARM_W-1:0]       warm_ff, warm_in;
   logic                    slope_ok_ff, slope_ok_in;
   logic                    rec_ff, rec_in;
   logic                    up_ff, up_in;
   logic                    act_ff, act_in;
   logic [IDX_W-1:0]        rec_idx_ff, rec_idx_in;
   logic [IDX_W-1:0]        fill_ff, fill_in;
   logic [ADDR_W-1:0]       run_idx_ff, run_idx_in;
   logic [SEEN_W-1:0]       aps_ff, aps_in;
   logic [CYC_W-1:0]        cyc_ff, cyc_in;
   logic [RM_W-1:0]         rm_ff, rm_in;
   logic signed [ERR_W-1:0] prev_ff, prev_in;
   logic [DRIVE_W-1:0]      drive_ff, drive_in;
   logic [DIV_NUM_W-1:0]    numer_ff, numer_in;
   logic [DIV_DEN_W-1:0]    denom_ff, denom_in;

   // template memory
   logic signed [VM_W-1:0]  tmpl_mem [TEMPLATE_DEPTH];
   logic signed [VM_W-1:0]  rd_data_ff;
   logic                    rd_zero_ff;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    rd_en;
   logic signed [VM_W-1:0]  wr_data;

   // combinational terms
   logic signed [ERR_W-1:0] diff;
   logic                    warm;
   logic                    slope_ok;
   logic                    aps_le_log;
   logic                    vm_above;
   logic                    up_cond;
   logic [LOG_W-1:0]        aps_m1;
   logic [20:0]             cyc_prod;
   logic [21:0]             cyc_n;
   logic signed [VM_W-1:0]  t_eff;
   logic signed [24:0]      tm_prod;
   logic signed [26:0]      tm_n;
   logic signed [ERR_W-1:0] err;
   logic [ERR_W-1:0]        err_mag;
   logic [ERR_W-1:0]        prev_mag;
   logic                    err_pos;
   logic [31:0]             cap_err;
   logic [FRAC_W-1:0]       frac_eff;
   logic [21:0]             cut_lim;
   logic [31:0]             run_scaled;
   logic [DIV_CNT_W-1:0]    qbits;
   logic                    div_done;
   logic [DIV_QUO_W-1:0]    quo;

   // slope detection against the sample LAG items back
   always_comb begin
      diff       = ERR_W'(vm_ff) - ERR_W'(ring_ff[pos_ff]);
      warm       = (warm_ff == WARM_FULL);
      slope_ok   = $signed({diff[ERR_W-1], diff}) >= $signed({2'b00, slope_ff});
      aps_le_log = aps_ff <= {1'b0, log_ff};
      vm_above   = vm_ff > vcut_ff;
      up_cond    = warm && slope_ok && aps_le_log && !up_ff && vm_above;
   end

   // averaging and correction arithmetic
   always_comb begin
      aps_m1   = aps_ff[LOG_W-1:0] - 1'b1;
      cyc_prod = cyc_ff * aps_m1;
      cyc_n    = 22'(cyc_prod) + 22'(rec_idx_ff);
      t_eff    = rd_zero_ff ? '0 : rd_data_ff;
      tm_prod  = t_eff * $signed({1'b0, aps_m1});
      tm_n     = 27'(tm_prod) + 27'(vm_ff) + $signed({4'b0000, aps_ff[LOG_W-1:0], 15'd0});
      err      = ERR_W'(vm_ff) - ERR_W'(t_eff);
      err_mag  = err[ERR_W-1] ? ERR_W'(-err) : err;
      prev_mag = prev_ff[ERR_W-1] ? ERR_W'(-prev_ff) : prev_ff;
      err_pos  = !err[ERR_W-1] && (err != '0);
      cap_err  = cap_ff * err[VM_W-1:0];
      frac_eff = (frac_ff > FRAC_MAX) ? FRAC_MAX : frac_ff;
      cut_lim  = frac_eff * cyc_ff;
      run_scaled = 32'({run_idx_ff, 8'd0});
   end

   // status back to the controller
   always_comb begin
      stat_o.cyc_needed = up_cond && (aps_ff != '0);
      stat_o.avg_go     = aps_le_log && rec_ff && (rec_idx_ff < DEPTH_IDX);
      stat_o.drive_div  = act_ff && err_pos && (cap_ff != '0) && (rm_ff != '0);
      stat_o.drive_ovf  = numer_ff >= (DIV_NUM_W'(denom_ff) << QBITS_DRIVE);
      stat_o.div_done   = div_done;
   end

   // next-state logic
   always_comb begin
      cap_in     = cap_ff;
      vcut_in    = vcut_ff;
      slope_in   = slope_ff;
      frac_in    = frac_ff;
      log_in     = log_ff;
      noise_in   = noise_ff;
      adapt_in   = adapt_ff;
      vm_in      = vm_ff;
      ring_in    = ring_ff;
      pos_in     = pos_ff;
      warm_in    = warm_ff;
      slope_ok_in = slope_ok_ff;
      rec_in     = rec_ff;
      up_in      = up_ff;
      act_in     = act_ff;
      rec_idx_in = rec_idx_ff;
      fill_in    = fill_ff;
      run_idx_in = run_idx_ff;
      aps_in     = aps_ff;
      cyc_in     = cyc_ff;
      rm_in      = rm_ff;
      prev_in    = prev_ff;
      drive_in   = drive_ff;
      numer_in   = numer_ff;
      denom_in   = denom_ff;
      wr_data    = $signed({~quo[DIV_QUO_W-1], quo[DIV_QUO_W-2:0]});

      // configuration writes
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAP_PF:       cap_in   = csr_wdata[CAP_W-1:0];
            CSR_RM_START:     rm_in    = csr_wdata[RM_W-1:0];
            CSR_V_CUTOFF:     vcut_in  = $signed(csr_wdata[VM_W-1:0]);
            CSR_SLOPE_THRESH: slope_in = csr_wdata[VM_W-1:0];
            CSR_CUT_FRAC:     frac_in  = csr_wdata[FRAC_W-1:0];
            CSR_LOG_COUNT:    log_in   = csr_wdata[LOG_W-1:0];
            CSR_NOISE_THRESH: noise_in = csr_wdata[VM_W-1:0];
            CSR_ADAPT_ENABLE: adapt_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (cmd_i.load_vm) begin
         vm_in = vm_i;
      end

      // ring update, upstroke detection, cycle average operands
      if (cmd_i.detect) begin
         ring_in[pos_ff] = vm_ff;
         pos_in      = (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;
         warm_in     = warm ? warm_ff : warm_ff + 1'b1;
         slope_ok_in = slope_ok;
         up_in       = up_cond || (up_ff && !diff[ERR_W-1]);
         numer_in    = DIV_NUM_W'({cyc_n, 1'b0}) + DIV_NUM_W'(aps_ff);
         denom_in    = DIV_DEN_W'({aps_ff, 1'b0});
         if (up_cond) begin
            rec_in     = 1'b1;
            rec_idx_in = '0;
            aps_in     = (aps_ff == SEEN_MAX) ? aps_ff : aps_ff + 1'b1;
            if (aps_ff == '0) begin
               cyc_in = '0;
            end
         end
      end

      if (cmd_i.cyc_write) begin
         cyc_in = (quo > DIV_QUO_W'(CYCLE_MAX)) ? CYCLE_MAX : quo[CYC_W-1:0];
      end

      // template average operands, offset to keep them nonnegative
      if (cmd_i.tmpl_prep) begin
         numer_in = DIV_NUM_W'({tm_n[24:0], 1'b0}) + DIV_NUM_W'(aps_ff[LOG_W-1:0]);
         denom_in = DIV_DEN_W'({aps_ff[LOG_W-1:0], 1'b0});
      end

      if (cmd_i.tmpl_write) begin
         rec_idx_in = rec_idx_ff + 1'b1;
         if (rec_idx_ff == fill_ff) begin
            fill_in = fill_ff + 1'b1;
         end
      end

      if (cmd_i.run_start) begin
         if (!act_ff && slope_ok_ff && !aps_le_log && vm_above) begin
            run_idx_in = '0;
            act_in     = 1'b1;
         end
      end

      // drive for the simple cases, rm adaptation, division operands
      if (cmd_i.run_eval && act_ff) begin
         if (!err_pos || cap_ff == '0) begin
            drive_in = '0;
         end else if (rm_ff == '0) begin
            drive_in = DRIVE_MAX;
         end
         numer_in = DIV_NUM_W'({cap_err, 10'd0});
         denom_in = rm_ff;
         if (adapt_ff && run_idx_ff > ADDR_W'(1)) begin
            if (err_mag > ERR_W'(noise_ff) && prev_ff != '0) begin
               if (prev_ff[ERR_W-1] != err[ERR_W-1]) begin
                  rm_in = rm_ff[RM_W-1] ? RM_MAX : {rm_ff[RM_W-2:0], 1'b0};
               end else if (prev_mag < err_mag && rm_ff >= RM_HALVE_MIN) begin
                  rm_in = rm_ff >> 1;
               end
            end
         end
         prev_in = err;
      end

      if (cmd_i.drive_check && stat_o.drive_ovf) begin
         drive_in = DRIVE_MAX;
      end

      if (cmd_i.drive_write) begin
         drive_in = (quo > DIV_QUO_W'(DRIVE_MAX)) ? DRIVE_MAX : quo[DRIVE_W-1:0];
      end

      // end of run and run index advance
      if (cmd_i.finish) begin
         if (run_scaled > 32'(cut_lim)) begin
            act_in   = 1'b0;
            drive_in = '0;
         end
         if (run_idx_ff != RUN_LAST) begin
            run_idx_in = run_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= CAP_RESET;
         vcut_ff     <= V_CUTOFF_RESET;
         slope_ff    <= SLOPE_RESET;
         frac_ff     <= FRAC_RESET;
         log_ff      <= LOG_RESET;
         noise_ff    <= NOISE_RESET;
         adapt_ff    <= 1'b1;
         for (int i = 0; i < LAG; i++) begin
            ring_ff[i] <= '0;
         end
         pos_ff      <= '0;
         warm_ff     <= '0;
         slope_ok_ff <= 1'b0;
         rec_ff      <= 1'b0;
         up_ff       <= 1'b0;
         act_ff      <= 1'b0;
         rec_idx_ff  <= '0;
         fill_ff     <= '0;
         run_idx_ff  <= '0;
         aps_ff      <= '0;
         cyc_ff      <= '0;
         rm_ff       <= RM_RESET;
         prev_ff     <= '0;
         drive_ff    <= '0;
      end else begin
         cap_ff      <= cap_in;
         vcut_ff     <= vcut_in;
         slope_ff    <= slope_in;
         frac_ff     <= frac_in;
         log_ff      <= log_in;
         noise_ff    <= noise_in;
         adapt_ff    <= adapt_in;
         ring_ff     <= ring_in;
         pos_ff      <= pos_in;
         warm_ff     <= warm_in;
         slope_ok_ff <= slope_ok_in;
         rec_ff      <= rec_in;
         up_ff       <= up_in;
         act_ff      <= act_in;
         rec_idx_ff  <= rec_idx_in;
         fill_ff     <= fill_in;
         run_idx_ff  <= run_idx_in;
         aps_ff      <= aps_in;
         cyc_ff      <= cyc_in;
         rm_ff       <= rm_in;
         prev_ff     <= prev_in;
         drive_ff    <= drive_in;
      end
      vm_ff    <= vm_in;
      numer_ff <= numer_in;
      denom_ff <= denom_in;
   end

   // template memory, entries at or past the fill count read as zero
   assign rd_addr = cmd_i.tmpl_read ? rec_idx_ff[ADDR_W-1:0] : run_idx_ff;
   assign rd_en   = cmd_i.tmpl_read || cmd_i.run_read;

   always_ff @(posedge clock) begin
      if (cmd_i.tmpl_write) begin
         tmpl_mem[rec_idx_ff[ADDR_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= tmpl_mem[rd_addr];
         rd_zero_ff <= IDX_W'(rd_addr) >= fill_ff;
      end
   end

   // divider width per operation
   always_comb begin
      case (cmd_i.div_op)
         DIV_CYCLE: qbits = QBITS_CYCLE;
         DIV_TMPL:  qbits = QBITS_TMPL;
         default:   qbits = QBITS_DRIVE;
      endcase
   end

   apfc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start_i (cmd_i.div_start),
      .qbits_i (qbits),
      .numer_i (numer_ff),
      .denom_i (denom_ff),
      .done_o  (div_done),
      .quo_o   (quo)
   );

   assign drive_o      = drive_ff;
   assign correcting_o = act_ff;
   assign aps_o        = aps_ff;
   assign cycle_o      = cyc_ff;

endmodule

// ===== src/apfc_ctrl.sv =====
// apfc_ctrl: sequencer that steps the datapath through one item and runs
// the handshakes. Uses apfc_pkg.
module apfc_ctrl
   import apfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output apfc_cmd_type  cmd_o,
   input  apfc_stat_type stat_i
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DETECT,
      ST_CYC_START,
      ST_CYC_WAIT,
      ST_TREAD,
      ST_TPREP,
      ST_TSTART,
      ST_TWAIT,
      ST_RSTART,
      ST_RREAD,
      ST_REVAL,
      ST_RCHECK,
      ST_RWAIT,
      ST_FINISH,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   // command decode and next state
   always_comb begin
      cmd_o    = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_o.load_vm = 1'b1;
               state_in      = ST_DETECT;
            end
         end
         ST_DETECT: begin
            cmd_o.detect = 1'b1;
            state_in     = stat_i.cyc_needed ? ST_CYC_START : ST_TREAD;
         end
         ST_CYC_START: begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_op    = DIV_CYCLE;
            state_in        = ST_CYC_WAIT;
         end
         ST_CYC_WAIT: begin
            if (stat_i.div_done) begin
               cmd_o.cyc_write = 1'b1;
               state_in        = ST_TREAD;
            end
         end
         ST_TREAD: begin
            cmd_o.tmpl_read = 1'b1;
            state_in        = stat_i.avg_go ? ST_TPREP : ST_RSTART;
         end
         ST_TPREP: begin
            cmd_o.tmpl_prep = 1'b1;
            state_in        = ST_TSTART;
         end
         ST_TSTART: begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_op    = DIV_TMPL;
            state_in        = ST_TWAIT;
         end
         ST_TWAIT: begin
            if (stat_i.div_done) begin
               cmd_o.tmpl_write = 1'b1;
               state_in         = ST_RSTART;
            end
         end
         ST_RSTART: begin
            cmd_o.run_start = 1'b1;
            state_in        = ST_RREAD;
         end
         ST_RREAD: begin
            cmd_o.run_read = 1'b1;
            state_in       = ST_REVAL;
         end
         ST_REVAL: begin
            cmd_o.run_eval = 1'b1;
            state_in       = stat_i.drive_div ? ST_RCHECK : ST_FINISH;
         end
         ST_RCHECK: begin
            cmd_o.drive_check = 1'b1;
            cmd_o.div_op      = DIV_DRIVE;
            if (stat_i.drive_ovf) begin
               state_in = ST_FINISH;
            end else begin
               cmd_o.div_start = 1'b1;
               state_in        = ST_RWAIT;
            end
         end
         ST_RWAIT: begin
            if (stat_i.div_done) begin
               cmd_o.drive_write = 1'b1;
               state_in          = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd_o.finish = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

endmodule

// ===== src/ap_template_feedback_corrector.sv =====
// ap_template_feedback_corrector: the longest items run three divisions, of
// 15, 16 and 13 quotient bits, on the one shared bit-serial divider. One item
// is in flight: the next is accepted in the cycle after the result is taken.
// Reset is synchronous and takes effect at once; the template memory needs no
// clearing pass, entries past its fill count read as zero.
module ap_template_feedback_corrector
   import apfc_pkg::*;
#(
   parameter int LAG            = 10,
   parameter int TEMPLATE_DEPTH = 8192
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [VM_W-1:0] req_vm_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [DRIVE_W-1:0]     rsp_drive_volts,
   output logic                   rsp_correcting,
   output logic [SEEN_W-1:0]      rsp_aps_seen,
   output logic [CYC_W-1:0]       rsp_cycle_samples,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   apfc_cmd_type  cmd;
   apfc_stat_type stat;

   // sequencer
   apfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd_o     (cmd),
      .stat_i    (stat)
   );

   // datapath and state
   apfc_datapath #(
      .LAG            (LAG),
      .TEMPLATE_DEPTH (TEMPLATE_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd_i        (cmd),
      .stat_o       (stat),
      .vm_i         (req_vm_sample),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .drive_o      (rsp_drive_volts),
      .correcting_o (rsp_correcting),
      .aps_o        (rsp_aps_seen),
      .cycle_o      (rsp_cycle_samples)
   );

endmodule

// ===== verif/ap_template_feedback_corrector_tb.sv =====
// ap_template_feedback_corrector_tb: drives membrane-voltage items and checks every result
// against a cycle-free predictor of the template corrector; random idling on both sides.
// Depends on apfc_pkg and ap_template_feedback_corrector.
module ap_template_feedback_corrector_tb;
   import apfc_pkg::*;

   localparam int LAG_LEN = 10;
   localparam int TDEPTH  = 8192;

   typedef struct packed {
      logic [DRIVE_W-1:0] drive;
      logic               active;
      logic [SEEN_W-1:0]  seen;
      logic [CYC_W-1:0]   cycle;
   } drive_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic signed [VM_W-1:0] req_vm_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [DRIVE_W-1:0]     rsp_drive_volts;
   logic                   rsp_correcting;
   logic [SEEN_W-1:0]      rsp_aps_seen;
   logic [CYC_W-1:0]       rsp_cycle_samples;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   drive_result_type drive_expected[$];
   int               error_count = 0;
   bit               no_idle = 1'b0;

   // corrector settings as seen by the predictor
   longint cfg_cap, cfg_rm_start, cfg_vcut, cfg_slope, cfg_frac, cfg_log, cfg_noise;
   bit     cfg_adapt;

   // corrector state as seen by the predictor
   logic signed [VM_W-1:0] lag_hist [LAG_LEN];
   int                     lag_ptr, warm_cnt;
   logic signed [VM_W-1:0] tmpl_mem [TDEPTH];
   longint                 rec_idx, run_idx, aps_cnt, cyc_avg, rm_cur, last_err, drive_lvl;
   bit                     recording, upstroke, active;

   ap_template_feedback_corrector u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_vm_sample,
      .rsp_valid, .rsp_stall, .rsp_drive_volts, .rsp_correcting,
      .rsp_aps_seen, .rsp_cycle_samples, .csr_we, .csr_index, .csr_wdata
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // round to nearest, halves up, d > 0
   function automatic longint round_div(longint n, longint d);
      longint num, den, q;
      num = 2 * n + d;
      den = 2 * d;
      q = num / den;
      if ((num % den) != 0 && num < 0) q--;
      return q;
   endfunction

   task automatic clear_model();
      cfg_cap = CAP_RESET; cfg_rm_start = RM_RESET; cfg_vcut = V_CUTOFF_RESET;
      cfg_slope = SLOPE_RESET; cfg_frac = FRAC_RESET; cfg_log = LOG_RESET;
      cfg_noise = NOISE_RESET; cfg_adapt = 1'b1;
      foreach (lag_hist[i]) lag_hist[i] = '0;
      foreach (tmpl_mem[i]) tmpl_mem[i] = '0;
      lag_ptr = 0; warm_cnt = 0; rec_idx = 0; run_idx = 0; aps_cnt = 0; cyc_avg = 0;
      recording = 0; upstroke = 0; active = 0;
      rm_cur = cfg_rm_start; last_err = 0; drive_lvl = 0;
   endtask

   // expected drive, run flag and averages for one voltage item
   function automatic drive_result_type correct_sample(logic signed [VM_W-1:0] sample);
      drive_result_type r;
      longint vm, diff, err, mag, pmag, q, frac;
      bit warm, slope_ok;
      vm = sample;
      diff = vm - longint'(lag_hist[lag_ptr]);
      lag_hist[lag_ptr] = sample;
      lag_ptr = (lag_ptr + 1 >= LAG_LEN) ? 0 : lag_ptr + 1;
      warm = warm_cnt >= LAG_LEN;
      if (warm_cnt < LAG_LEN) warm_cnt++;
      slope_ok = diff >= cfg_slope;

      // upstroke while building the template
      if (warm && slope_ok && aps_cnt <= cfg_log && !upstroke && vm > cfg_vcut) begin
         if (aps_cnt == 0) cyc_avg = 0;
         else begin
            q = round_div(cyc_avg * (aps_cnt - 1) + rec_idx, aps_cnt);
            cyc_avg = (q > 8191) ? 8191 : q;
         end
         recording = 1; rec_idx = 0; upstroke = 1;
         if (aps_cnt < 256) aps_cnt++;
      end
      if (diff < 0 && upstroke) upstroke = 0;

      // running template average
      if (aps_cnt <= cfg_log && recording && rec_idx < TDEPTH) begin
         tmpl_mem[rec_idx] = VM_W'(round_div(longint'(tmpl_mem[rec_idx]) * (aps_cnt - 1) + vm,
                                             aps_cnt));
         rec_idx++;
      end

      if (!active && slope_ok && aps_cnt > cfg_log && vm > cfg_vcut) begin
         run_idx = 0; active = 1;
      end

      // feedback drive and resistance adaptation
      if (active) begin
         err = vm - longint'(tmpl_mem[run_idx]);
         if (err <= 0 || cfg_cap == 0) drive_lvl = 0;
         else if (rm_cur == 0) drive_lvl = 5120;
         else begin
            q = (1024 * cfg_cap * err) / rm_cur;
            drive_lvl = (q > 5120) ? 5120 : q;
         end
         if (cfg_adapt && run_idx > 1) begin
            mag = err < 0 ? -err : err;
            pmag = last_err < 0 ? -last_err : last_err;
            if (mag > cfg_noise && last_err != 0) begin
               if ((last_err < 0) != (err < 0))
                  rm_cur = (rm_cur * 2 > 24'hFFFFFF) ? 24'hFFFFFF : rm_cur * 2;
               else if (pmag < mag && rm_cur * 100 >= 512)
                  rm_cur = rm_cur >> 1;
            end
         end
         last_err = err;
      end

      frac = cfg_frac > 256 ? 256 : cfg_frac;
      if (run_idx * 256 > frac * cyc_avg) begin
         active = 0; drive_lvl = 0;
      end
      if (run_idx < TDEPTH - 1) run_idx++;

      r.drive  = DRIVE_W'(drive_lvl);
      r.active = active;
      r.seen   = SEEN_W'(aps_cnt);
      r.cycle  = CYC_W'(cyc_avg);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_expected.size() == 0) report_mismatch("unexpected item", 1, 0);
         else begin
            want = drive_expected.pop_front();
            if (rsp_drive_volts !== want.drive)
               report_mismatch("drive_volts", rsp_drive_volts, want.drive);
            if (rsp_correcting !== want.active)
               report_mismatch("correcting", rsp_correcting, want.active);
            if (rsp_aps_seen !== want.seen)
               report_mismatch("aps_seen", rsp_aps_seen, want.seen);
            if (rsp_cycle_samples !== want.cycle)
               report_mismatch("cycle_samples", rsp_cycle_samples, want.cycle);
         end
      end
   end

   // receiver stalls
   always @(negedge clock)
      rsp_stall <= !no_idle && ($urandom_range(99) < 17);

   // send one item; called and returning at a falling edge
   task automatic send_sample(int v);
      logic signed [VM_W-1:0] s;
      s = VM_W'((v > 32767) ? 32767 : (v < -32768) ? -32768 : v);
      while (!no_idle && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_vm_sample <= s;
      do @(posedge clock); while (req_stall);
      drive_expected.push_back(correct_sample(s));
      @(negedge clock);
   endtask

   // wait until the block is idle
   task automatic drain();
      req_valid <= 1'b0;
      while (drive_expected.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, longint value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_CAP_PF:       cfg_cap = value & 16'hFFFF;
         CSR_RM_START:     begin cfg_rm_start = value & 24'hFFFFFF; rm_cur = cfg_rm_start; end
         CSR_V_CUTOFF:     cfg_vcut = longint'($signed(value[15:0]));
         CSR_SLOPE_THRESH: cfg_slope = value & 16'hFFFF;
         CSR_CUT_FRAC:     cfg_frac = value & 9'h1FF;
         CSR_LOG_COUNT:    cfg_log = value & 8'hFF;
         CSR_NOISE_THRESH: cfg_noise = value & 16'hFFFF;
         CSR_ADAPT_ENABLE: cfg_adapt = value[0];
         default: ;
      endcase
   endtask

   // one action-potential-like beat: rest, three-sample upstroke, linear decay
   task automatic send_beat(int rest, int peak, int len);
      int v;
      for (int i = 0; i < len; i++) begin
         if (i < 5) v = rest;
         else if (i < 8) v = rest + (peak - rest) * (i - 4) / 3;
         else v = peak - (peak - rest) * (i - 7) / (len - 7);
         send_sample(v + int'($urandom_range(100)) - 50);
      end
   endtask

   task automatic random_beat();
      send_beat(-20000 + int'($urandom_range(2000)), int'($urandom_range(9000)) - 2000,
                20 + $urandom_range(50));
   endtask

   // field extremes and warm-up against an empty lag ring
   task automatic test_extremes();
      int pattern [12] = '{32767, -32768, 0, -1, 1, 21845, -21846, 32767, -32768,
                           255, -256, 4660};
      foreach (pattern[i]) send_sample(pattern[i]);
   endtask

   // the first beats build the template and the cycle average
   task automatic test_template_build();
      repeat (4) send_beat(-20000, 5000, 40);
   endtask

   // later beats start correction runs
   task automatic test_correction_runs();
      repeat (6) random_beat();
      drain();
      write_reg(CSR_ADAPT_ENABLE, 0);
      repeat (3) random_beat();
      drain();
      write_reg(CSR_ADAPT_ENABLE, 1);
   endtask

   // register corners: zero and full-scale capacitance, tiny and full-scale resistance, cutoff extremes
   task automatic test_register_corners();
      drain();
      write_reg(CSR_CAP_PF, 0);
      write_reg(CSR_CUT_FRAC, 511);
      repeat (2) random_beat();
      drain();
      write_reg(CSR_CAP_PF, 65535);
      write_reg(CSR_RM_START, 5);
      write_reg(CSR_NOISE_THRESH, 0);
      write_reg(CSR_CUT_FRAC, 0);
      repeat (2) random_beat();
      drain();
      write_reg(CSR_RM_START, 16777215);
      write_reg(CSR_NOISE_THRESH, 65535);
      write_reg(CSR_CUT_FRAC, 256);
      write_reg(CSR_SLOPE_THRESH, 0);
      write_reg(CSR_V_CUTOFF, 16'h8000);
      repeat (2) random_beat();
      drain();
      write_reg(CSR_SLOPE_THRESH, 65535);
      write_reg(CSR_V_CUTOFF, 32767);
      write_reg(CSR_LOG_COUNT, 0);
      test_extremes();
      drain();
      write_reg(CSR_LOG_COUNT, 255);
      repeat (3) random_beat();
      drain();
      write_reg(CSR_CAP_PF, 150);
      write_reg(CSR_RM_START, 38400);
      write_reg(CSR_V_CUTOFF, 16'hD800);
      write_reg(CSR_SLOPE_THRESH, 1280);
      write_reg(CSR_NOISE_THRESH, 512);
      write_reg(CSR_CUT_FRAC, 251);
   endtask

   // random beats with noise, several settings
   task automatic test_random_beats();
      int sent;
      for (int phase = 0; phase < 4; phase++) begin
         drain();
         write_reg(CSR_CAP_PF, 1 + $urandom_range(2000));
         write_reg(CSR_RM_START, 5 + $urandom_range(100000));
         write_reg(CSR_NOISE_THRESH, $urandom_range(3000));
         write_reg(CSR_CUT_FRAC, 128 + $urandom_range(200));
         write_reg(CSR_ADAPT_ENABLE, $urandom_range(1));
         if (phase == 2) write_reg(CSR_LOG_COUNT, aps_cnt + 2);
         no_idle = (phase == 1);
         sent = 0;
         while (sent < 60) begin
            if ($urandom_range(9) == 0) begin
               send_sample(int'($urandom_range(65535)) - 32768);
               sent++;
            end else begin
               random_beat();
               sent += 45;
            end
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      clear_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_extremes();
      test_template_build();
      test_correction_runs();
      test_register_corners();
      test_random_beats();
      drain();
      if (error_count == 0) $display("ap_template_feedback_corrector_tb: clean");
      else $display("ap_template_feedback_corrector_tb: errors");
      $finish;
   end

   initial begin
      #20000000;
      $display("ap_template_feedback_corrector_tb: errors");
      $finish;
   end

endmodule

// ===== ap_template_feedback_corrector.f =====
src/apfc_pkg.sv
src/apfc_divider.sv
src/apfc_datapath.sv
src/apfc_ctrl.sv
src/ap_template_feedback_corrector.sv
verif/ap_template_feedback_corrector_tb.sv
